// File: src/sorg_pkg.sv
`timescale 1ns / 1ps
package sorg_pkg;

  localparam int unsigned MaxProfile  = 256;
  localparam int unsigned MaxDivs     = 256;
  localparam int unsigned SineBits    = 10;
  localparam int unsigned Quarter     = 1 << (SineBits - 2);
  localparam int unsigned AddrW       = $clog2(MaxProfile);
  localparam int unsigned CntW        = AddrW + 1;
  localparam int unsigned DivCntW     = $clog2(MaxDivs) + 1;
  localparam int unsigned IdxW        = 17;
  localparam int unsigned QtrW        = SineBits - 2;

  typedef enum logic [2:0] {
    CMD_LOAD   = 3'd0,
    CMD_VERTEX = 3'd1,
    CMD_CAPCTR = 3'd2,
    CMD_QUAD   = 3'd3,
    CMD_CAPTRI = 3'd4
  } cmd_e;

  typedef enum logic [2:0] {
    REG_NDIV  = 3'd0,
    REG_AXIS  = 3'd1,
    REG_CAPS  = 3'd2,
    REG_NPTS  = 3'd3,
    REG_PHASE = 3'd4
  } reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD_FIRST,
    ST_RD_LAST,
    ST_RD_RING,
    ST_MUL,
    ST_SUM,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic [2:0]  command;
    logic [7:0]  ring_index;
    logic [7:0]  division;
    logic        cap_end;
    logic signed [31:0] x_coord;
    logic signed [31:0] y_coord;
    logic signed [31:0] z_coord;
  } req_t;

  typedef struct packed {
    logic        status;
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;
    logic [2:0]  corner_count;
    logic [IdxW-1:0] corner_a;
    logic [IdxW-1:0] corner_b;
    logic [IdxW-1:0] corner_c;
    logic [IdxW-1:0] corner_d;
  } rsp_t;

  typedef struct packed {
    logic        latch_req;
    logic        store_wr;
    logic [1:0]  rd_sel;
    logic        cap_first;
    logic        cap_last;
    logic        cap_ring;
    logic        do_mul;
    logic        do_sum;
  } ctrl_t;

  typedef struct packed {
    logic is_load;
  } stat_t;

  localparam logic [1:0] RD_FIRST = 2'd0;
  localparam logic [1:0] RD_LAST  = 2'd1;
  localparam logic [1:0] RD_RING  = 2'd2;

  // quarter-wave sine entry in Q2.30, evaluated at elaboration only
  function automatic logic [31:0] sin_series(input int unsigned k);
    logic [63:0] x, x2, t, s;
    logic [63:0] halfpi;
    begin
      halfpi = 64'd1686629713;
      x  = (64'(k) * halfpi + 64'(Quarter / 2)) / 64'(Quarter);
      x2 = (x * x + (64'd1 << 29)) >> 30;
      t  = x;
      s  = x;
      for (int n = 1; n <= 7; n++) begin
        t = ((t * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
        if ((n % 2) == 1) s = s - t;
        else s = s + t;
      end
      if ($signed(s) < 0) s = '0;
      if ($signed(s) > $signed(64'd1073741824)) s = 64'd1073741824;
      if (k == Quarter) s = 64'd1073741824;
      sin_series = s[31:0];
    end
  endfunction

endpackage

// File: src/sorg_if.sv
`timescale 1ns / 1ps
interface sorg_req_if;
  logic valid;
  logic ready;
  sorg_pkg::req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface sorg_rsp_if;
  logic valid;
  logic ready;
  sorg_pkg::rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface sorg_cfg_if;
  logic valid;
  logic ready;
  logic [2:0] index;
  logic [15:0] wdata;
  modport source (output valid, output index, output wdata, input ready);
  modport sink (input valid, input index, input wdata, output ready);
endinterface

// File: src/sorg_ctrl.sv
`timescale 1ns / 1ps
module sorg_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            req_valid_i,
  output logic            req_ready_o,
  output logic            rsp_valid_o,
  input  logic            rsp_ready_i,
  input  sorg_pkg::stat_t stat_i,
  output sorg_pkg::ctrl_t ctrl_o
);

  sorg_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sorg_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      sorg_pkg::ST_IDLE: begin
        if (req_valid_i) state_d = sorg_pkg::ST_RD_FIRST;
      end
      sorg_pkg::ST_RD_FIRST: begin
        state_d = stat_i.is_load ? sorg_pkg::ST_IDLE : sorg_pkg::ST_RD_LAST;
      end
      sorg_pkg::ST_RD_LAST: state_d = sorg_pkg::ST_RD_RING;
      sorg_pkg::ST_RD_RING: state_d = sorg_pkg::ST_MUL;
      sorg_pkg::ST_MUL: state_d = sorg_pkg::ST_SUM;
      sorg_pkg::ST_SUM: state_d = sorg_pkg::ST_OUT;
      sorg_pkg::ST_OUT: begin
        if (rsp_ready_i) state_d = sorg_pkg::ST_IDLE;
      end
      default: state_d = sorg_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    ctrl_o       = '0;
    req_ready_o  = 1'b0;
    rsp_valid_o  = 1'b0;
    unique case (state_q)
      sorg_pkg::ST_IDLE: begin
        req_ready_o       = 1'b1;
        ctrl_o.latch_req  = req_valid_i;
      end
      sorg_pkg::ST_RD_FIRST: begin
        ctrl_o.store_wr = stat_i.is_load;
        ctrl_o.rd_sel   = sorg_pkg::RD_FIRST;
      end
      sorg_pkg::ST_RD_LAST: begin
        ctrl_o.rd_sel    = sorg_pkg::RD_LAST;
        ctrl_o.cap_first = 1'b1;
      end
      sorg_pkg::ST_RD_RING: begin
        ctrl_o.rd_sel   = sorg_pkg::RD_RING;
        ctrl_o.cap_last = 1'b1;
      end
      sorg_pkg::ST_MUL: begin
        ctrl_o.cap_ring = 1'b1;
        ctrl_o.do_mul   = 1'b1;
      end
      sorg_pkg::ST_SUM: begin
        ctrl_o.do_sum = 1'b1;
      end
      sorg_pkg::ST_OUT: begin
        rsp_valid_o = 1'b1;
      end
      default: ;
    endcase
  end

endmodule

// File: src/sorg_dp.sv
`timescale 1ns / 1ps
module sorg_dp (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  sorg_pkg::ctrl_t ctrl_i,
  output sorg_pkg::stat_t stat_o,
  input  sorg_pkg::req_t  req_i,
  output sorg_pkg::rsp_t  rsp_o,
  input  logic            cfg_we_i,
  input  logic [2:0]      cfg_index_i,
  input  logic [15:0]     cfg_wdata_i
);

  localparam int unsigned AW = sorg_pkg::AddrW;
  localparam int unsigned CW = sorg_pkg::CntW;
  localparam int unsigned DW = sorg_pkg::DivCntW;
  localparam int unsigned SB = sorg_pkg::SineBits;
  localparam int unsigned QW = sorg_pkg::QtrW;

  logic [8:0]  ndiv_q;
  logic [1:0]  axis_q;
  logic        caps_q;
  logic [8:0]  npts_q;
  logic [15:0] phase_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ndiv_q  <= 9'd4;
      axis_q  <= 2'd0;
      caps_q  <= 1'b0;
      npts_q  <= 9'd2;
      phase_q <= 16'd16384;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        sorg_pkg::REG_NDIV:  ndiv_q  <= cfg_wdata_i[8:0];
        sorg_pkg::REG_AXIS:  axis_q  <= cfg_wdata_i[1:0];
        sorg_pkg::REG_CAPS:  caps_q  <= cfg_wdata_i[0];
        sorg_pkg::REG_NPTS:  npts_q  <= cfg_wdata_i[8:0];
        sorg_pkg::REG_PHASE: phase_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  logic [CW-1:0] n_eff;
  logic [DW-1:0] d_eff;
  logic [1:0]    ax;
  always_comb begin
    n_eff = (npts_q == 9'd0) ? CW'(1) :
            ({23'd0, npts_q} > 32'(sorg_pkg::MaxProfile)) ? CW'(sorg_pkg::MaxProfile)
            : CW'(npts_q);
    d_eff = (ndiv_q == 9'd0) ? DW'(1) :
            ({23'd0, ndiv_q} > 32'(sorg_pkg::MaxDivs)) ? DW'(sorg_pkg::MaxDivs)
            : DW'(ndiv_q);
    ax = (axis_q == 2'd3) ? 2'd2 : axis_q;
  end

  sorg_pkg::req_t r_q;
  always_ff @(posedge clk_i) begin
    if (ctrl_i.latch_req) r_q <= req_i;
  end

  assign stat_o.is_load = (r_q.command == sorg_pkg::CMD_LOAD);

  logic [31:0] mem_x [sorg_pkg::MaxProfile];
  logic [31:0] mem_y [sorg_pkg::MaxProfile];
  logic [31:0] mem_z [sorg_pkg::MaxProfile];
  logic [AW-1:0] rd_addr;
  logic [31:0] rd_x_q, rd_y_q, rd_z_q;
  logic [CW-1:0] n_m1;
  assign n_m1 = n_eff - CW'(1);

  always_comb begin
    case (ctrl_i.rd_sel)
      sorg_pkg::RD_FIRST: rd_addr = '0;
      sorg_pkg::RD_LAST:  rd_addr = n_m1[AW-1:0];
      default:            rd_addr = AW'(r_q.ring_index);
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.store_wr && ({24'd0, r_q.ring_index} < 32'(sorg_pkg::MaxProfile))) begin
      mem_x[AW'(r_q.ring_index)] <= r_q.x_coord;
      mem_y[AW'(r_q.ring_index)] <= r_q.y_coord;
      mem_z[AW'(r_q.ring_index)] <= r_q.z_coord;
    end
    rd_x_q <= mem_x[rd_addr];
    rd_y_q <= mem_y[rd_addr];
    rd_z_q <= mem_z[rd_addr];
  end

  function automatic logic signed [31:0] pick(input logic [1:0] a, input logic [31:0] x,
                                              input logic [31:0] y, input logic [31:0] z);
    case (a)
      2'd0:    pick = x;
      2'd1:    pick = y;
      default: pick = z;
    endcase
  endfunction

  logic signed [31:0] fa_q, la_q;
  logic [31:0] first_x_q, first_y_q, first_z_q, last_x_q, last_y_q, last_z_q;
  logic signed [31:0] va_q, vu, vw;
  logic [15:0] ph_mul_q;
  always_ff @(posedge clk_i) begin
    if (ctrl_i.cap_first) begin
      first_x_q <= rd_x_q; first_y_q <= rd_y_q; first_z_q <= rd_z_q;
    end
    if (ctrl_i.cap_last) begin
      last_x_q <= rd_x_q; last_y_q <= rd_y_q; last_z_q <= rd_z_q;
    end
    if (ctrl_i.cap_ring) va_q <= pick(ax, rd_x_q, rd_y_q, rd_z_q);
    if (ctrl_i.cap_first) ph_mul_q <= 16'(r_q.division) * phase_q;
  end
  assign fa_q = pick(ax, first_x_q, first_y_q, first_z_q);
  assign la_q = pick(ax, last_x_q, last_y_q, last_z_q);
  assign vu = pick((ax == 2'd2) ? 2'd0 : ax + 2'd1, rd_x_q, rd_y_q, rd_z_q);
  assign vw = pick((ax == 2'd0) ? 2'd2 : ax - 2'd1, rd_x_q, rd_y_q, rd_z_q);

  // constant quarter-wave table, Quarter + 1 entries
  logic [31:0] sine_tbl [sorg_pkg::Quarter+1];
  for (genvar k = 0; k <= sorg_pkg::Quarter; k++) begin : g_sine
    localparam logic [31:0] SineVal = sorg_pkg::sin_series(k);
    assign sine_tbl[k] = SineVal;
  end

  function automatic logic [QW:0] fold(input logic [SB-1:0] i);
    fold = i[SB-2] ? ((QW+1)'(sorg_pkg::Quarter) - {1'b0, i[QW-1:0]}) : {1'b0, i[QW-1:0]};
  endfunction

  logic [15:0] ph;
  logic [SB-1:0] idx, cidx;
  logic signed [31:0] sn_mag, cs_mag, sn_q, cs_q;
  assign ph     = ph_mul_q;
  assign idx    = SB'((17'(ph) + 17'(1 << (15 - SB))) >> (16 - SB));
  assign cidx   = idx + SB'(sorg_pkg::Quarter);
  assign sn_mag = $signed(sine_tbl[fold(idx)]);
  assign cs_mag = $signed(sine_tbl[fold(cidx)]);

  always_ff @(posedge clk_i) begin
    if (ctrl_i.cap_last) begin
      sn_q <= idx[SB-1] ? -sn_mag : sn_mag;
      cs_q <= cidx[SB-1] ? -cs_mag : cs_mag;
    end
  end

  logic signed [63:0] p_cu_q, p_sw_q, p_su_q, p_cw_q;
  always_ff @(posedge clk_i) begin
    if (ctrl_i.do_mul) begin
      p_cu_q <= cs_q * vu;
      p_sw_q <= sn_q * vw;
      p_su_q <= sn_q * vu;
      p_cw_q <= cs_q * vw;
    end
  end

  function automatic logic signed [31:0] rsat(input logic signed [64:0] v);
    logic signed [64:0] t;
    logic signed [34:0] r;
    begin
      t = v + 65'sd536870912;
      r = 35'(t >>> 30);
      if (r > 35'sd2147483647) rsat = 32'sh7fffffff;
      else if (r < -35'sd2147483648) rsat = 32'sh80000000;
      else rsat = r[31:0];
    end
  endfunction

  logic signed [31:0] ru, rw;
  assign ru = rsat(65'(p_cu_q) - 65'(p_sw_q));
  assign rw = rsat(65'(p_su_q) + 65'(p_cw_q));

  logic bottom;
  assign bottom = fa_q < la_q;

  logic ring_bad, div_bad;
  assign ring_bad = {1'b0, r_q.ring_index} >= CW'(n_eff);
  assign div_bad  = DW'(r_q.division) >= d_eff;

  logic [DW-1:0] j1, nj0;
  logic [CW-1:0] i1, ni0;
  logic [31:0] a_i, b_i, c_i, e_i, t1, t2, ctr;
  always_comb begin
    j1  = DW'(r_q.division) + DW'(1);
    nj0 = (j1 == d_eff) ? '0 : j1;
    i1  = CW'(r_q.ring_index) + CW'(1);
    ni0 = (i1 == n_eff) ? '0 : i1;
    a_i = 32'(i1) + 32'(nj0) * 32'(n_eff);
    b_i = 32'(i1) + 32'(r_q.division) * 32'(n_eff);
    c_i = 32'(ni0) + 32'd1 + 32'(r_q.division) * 32'(n_eff);
    e_i = 32'(ni0) + 32'd1 + 32'(nj0) * 32'(n_eff);
    t1  = (r_q.cap_end ? 32'(n_eff) : 32'd1) + 32'(r_q.division) * 32'(n_eff);
    t2  = (r_q.cap_end ? 32'(n_eff) : 32'd1) + 32'(nj0) * 32'(n_eff);
    ctr = 32'(d_eff) * 32'(n_eff) + (r_q.cap_end ? 32'd2 : 32'd1);
  end

  sorg_pkg::rsp_t res;
  logic swp;
  always_comb begin
    res = '0;
    swp = r_q.cap_end ? !bottom : bottom;
    case (r_q.command)
      sorg_pkg::CMD_VERTEX: begin
        if (ring_bad || div_bad) res.status = 1'b1;
        else begin
          unique case (ax)
            2'd0: begin res.out_x = va_q; res.out_y = ru; res.out_z = rw; end
            2'd1: begin res.out_y = va_q; res.out_z = ru; res.out_x = rw; end
            default: begin res.out_z = va_q; res.out_x = ru; res.out_y = rw; end
          endcase
        end
      end
      sorg_pkg::CMD_CAPCTR: begin
        if (!caps_q) res.status = 1'b1;
        else begin
          unique case (ax)
            2'd0: res.out_x = r_q.cap_end ? la_q : fa_q;
            2'd1: res.out_y = r_q.cap_end ? la_q : fa_q;
            default: res.out_z = r_q.cap_end ? la_q : fa_q;
          endcase
        end
      end
      sorg_pkg::CMD_QUAD: begin
        if (div_bad || ring_bad || (caps_q && (i1 >= n_eff))) res.status = 1'b1;
        else begin
          res.corner_count = 3'd4;
          if (caps_q && bottom) begin
            res.corner_a = e_i[16:0]; res.corner_b = c_i[16:0];
            res.corner_c = b_i[16:0]; res.corner_d = a_i[16:0];
          end else begin
            res.corner_a = a_i[16:0]; res.corner_b = b_i[16:0];
            res.corner_c = c_i[16:0]; res.corner_d = e_i[16:0];
          end
        end
      end
      sorg_pkg::CMD_CAPTRI: begin
        if (!caps_q || div_bad) res.status = 1'b1;
        else begin
          res.corner_count = 3'd3;
          res.corner_a = swp ? t2[16:0] : t1[16:0];
          res.corner_b = swp ? t1[16:0] : t2[16:0];
          res.corner_c = ctr[16:0];
        end
      end
      default: res.status = 1'b1;
    endcase
  end

  sorg_pkg::rsp_t rsp_q;
  always_ff @(posedge clk_i) begin
    if (ctrl_i.do_sum) rsp_q <= res;
  end
  assign rsp_o = rsp_q;

endmodule

// File: src/surface_of_revolution_generator_core.sv
`timescale 1ns / 1ps
// Lathe tessellator. One request is in flight at a time. A load holds the
// block through accept and store write. A query holds it through accept,
// three reads of the single-port profile store (first point, last point,
// queried point; the sine lookup is registered alongside the last read),
// the rotation multiplies, rounding, saturation and registering of the
// result, and presenting it, which lasts until the result is taken.
module surface_of_revolution_generator_core (
  input  logic clk_i,
  input  logic rst_ni,
  sorg_req_if.sink   req,
  sorg_rsp_if.source rsp,
  sorg_cfg_if.sink   cfg
);

  sorg_pkg::ctrl_t ctrl;
  sorg_pkg::stat_t stat;

  assign cfg.ready = 1'b1;

  sorg_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req.valid),
    .req_ready_o (req.ready),
    .rsp_valid_o (rsp.valid),
    .rsp_ready_i (rsp.ready),
    .stat_i      (stat),
    .ctrl_o      (ctrl)
  );

  sorg_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (ctrl),
    .stat_o      (stat),
    .req_i       (req.data),
    .rsp_o       (rsp.data),
    .cfg_we_i    (cfg.valid),
    .cfg_index_i (cfg.index),
    .cfg_wdata_i (cfg.wdata)
  );

endmodule

// File: src/sorg_checker.sv
`timescale 1ns / 1ps
module sorg_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic req_valid,
  input logic req_ready,
  input logic rsp_valid,
  input logic rsp_ready,
  input sorg_pkg::rsp_t rsp_data
);

  a_no_accept_while_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid |-> !req_ready) else $error("request taken while result pending");

  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
    else $error("result dropped");

  a_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid && req_ready |=> !req_ready) else $error("back to back accept");

  a_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid && !rsp_data.status |-> rsp_data.corner_count != 3'd1 &&
    rsp_data.corner_count != 3'd2) else $error("bad corner count");

endmodule

bind surface_of_revolution_generator_core sorg_checker u_chk (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .req_valid (req.valid),
  .req_ready (req.ready),
  .rsp_valid (rsp.valid),
  .rsp_ready (rsp.ready),
  .rsp_data  (rsp.data)
);
